>>> design/b64d_pkg.sv
// Shared types, constants and the character classifier for the base64 decoder.
`default_nettype none
package b64d_pkg;

    // Command queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    localparam logic [5:0] SX_LOWER_BASE = 6'd26;
    localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SX_PLUS       = 6'd62;
    localparam logic [5:0] SX_SLASH      = 6'd63;

    // One queued command: up to three result beats.
    typedef struct packed {
        logic [23:0] bits;      // group, MSB-aligned
        logic [1:0]  count;     // number of beats, 1..3
        logic        has_data;  // beats carry bytes
        logic        bad;       // illegal-character beat
        logic        endt;      // final beat closes the text
    } t_cmd;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

    // Bit 6 set: illegal character.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            v = {1'b0, 6'(c - CH_UPPER_A)};
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            v = {1'b0, 6'(c - CH_LOWER_A) + SX_LOWER_BASE};
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            v = {1'b0, 6'(c - CH_DIGIT_0) + SX_DIGIT_BASE};
        end else if (c == CH_PLUS) begin
            v = {1'b0, SX_PLUS};
        end else if (c == CH_SLASH) begin
            v = {1'b0, SX_SLASH};
        end else begin
            v = 7'h40;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

>>> design/b64d_if.sv
// Valid/ready channel interfaces for characters in and results out.
`default_nettype none
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;
    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       bad_char;
    logic       end_of_text;
    modport source (output valid, output data_byte, output byte_valid,
                    output bad_char, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input bad_char, input end_of_text, output ready);
endinterface
`default_nettype wire

>>> design/b64d_front.sv
// Front: accepts characters, tracks the group and skip state, issues commands.
`default_nettype none
module b64d_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_char_code,
    input  wire logic             i_last_char,
    input  wire logic             i_q_full,
    output logic                  o_ready,
    output logic                  o_push,
    output b64d_pkg::t_cmd        o_cmd
);
    logic [17:0] r_group, n_group;
    logic [1:0]  r_held, n_held;
    logic        r_skip, n_skip;
    logic        accept;
    logic [6:0]  sx;
    logic [23:0] acc;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign sx      = b64d_pkg::sextet_of(i_char_code);
    assign acc     = {r_group, sx[5:0]};

    always_comb begin
        n_group = r_group;
        n_held  = r_held;
        n_skip  = r_skip;
        o_push  = 1'b0;
        o_cmd   = '0;
        if (accept) begin
            priority if (r_skip) begin
                if (i_last_char) n_skip = 1'b0;
            end else if (i_last_char && r_held == 2'd0) begin
                // lone trailing char: dropped unchecked, end marker only
                o_push     = 1'b1;
                o_cmd.count = 2'd1;
                o_cmd.endt = 1'b1;
            end else if (sx[6]) begin
                o_push      = 1'b1;
                o_cmd.count = 2'd1;
                o_cmd.bad   = 1'b1;
                o_cmd.endt  = 1'b1;
                n_group     = '0;
                n_held      = '0;
                n_skip      = !i_last_char;
            end else if (r_held != 2'd3 && !i_last_char) begin
                n_group = acc[17:0];
                n_held  = r_held + 2'd1;
            end else begin
                o_push         = 1'b1;
                o_cmd.count    = r_held;
                o_cmd.has_data = 1'b1;
                o_cmd.endt     = i_last_char;
                unique case (r_held)
                    2'd3:    o_cmd.bits = acc;
                    2'd2:    o_cmd.bits = {acc[17:0], 6'd0};
                    default: o_cmd.bits = {acc[11:0], 12'd0};
                endcase
                n_group = '0;
                n_held  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group <= '0;
            r_held  <= '0;
            r_skip  <= 1'b0;
        end else begin
            r_group <= n_group;
            r_held  <= n_held;
            r_skip  <= n_skip;
        end
    end
endmodule
`default_nettype wire

>>> design/b64d_queue.sv
// Small command FIFO between front and back.
`default_nettype none
module b64d_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire b64d_pkg::t_cmd       i_cmd,
    input  wire logic                 i_pop,
    output b64d_pkg::t_cmd            o_head,
    output b64d_pkg::t_q_stat         o_stat
);
    b64d_pkg::t_cmd r_mem [b64d_pkg::QDEPTH];
    logic [b64d_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [b64d_pkg::QCNT_W-1:0] r_cnt, n_cnt;
    logic do_push, do_pop;

    assign o_stat.full     = (r_cnt == b64d_pkg::QCNT_W'(b64d_pkg::QDEPTH));
    assign o_stat.nonempty = (r_cnt != '0);
    assign o_head          = r_mem[r_rd];
    assign do_push         = i_push && !o_stat.full;
    assign do_pop          = i_pop && o_stat.nonempty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) n_cnt = r_cnt + 1'b1;
        if (!do_push && do_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

>>> design/b64d_back.sv
// Back: walks the head command beat by beat into the output register.
`default_nettype none
module b64d_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire b64d_pkg::t_cmd    i_head,
    input  wire logic              i_head_valid,
    output logic                   o_pop,
    b64d_out_if.source             o_out
);
    logic [1:0] r_idx, n_idx;
    logic       r_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_bval, r_bad, r_end;
    logic       load, last_beat;

    assign load      = i_head_valid && (!r_valid || o_out.ready);
    assign last_beat = (r_idx + 2'd1) == i_head.count;
    assign o_pop     = load && last_beat;
    assign n_idx     = last_beat ? 2'd0 : r_idx + 2'd1;

    always_comb begin
        unique case (r_idx)
            2'd0:    n_byte = i_head.bits[23:16];
            2'd1:    n_byte = i_head.bits[15:8];
            default: n_byte = i_head.bits[7:0];
        endcase
        if (!i_head.has_data) n_byte = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) r_idx <= n_idx;
            if (load) r_valid <= 1'b1;
            else if (o_out.ready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_bval <= i_head.has_data;
            r_bad  <= i_head.bad;
            r_end  <= i_head.endt && last_beat;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.data_byte   = r_byte;
    assign o_out.byte_valid  = r_bval;
    assign o_out.bad_char    = r_bad;
    assign o_out.end_of_text = r_end;
endmodule
`default_nettype wire

>>> design/base64_unpadded_decoder_unit.sv
// Top level of the streaming base64 (unpadded) decoder.
`default_nettype none
// Streaming base64 decoder for text without '=' padding. One character is
// taken per beat on i_in, with last_char on the final one; every cycle can
// accept a beat while the command queue has room. A group of four
// characters gives three byte beats, a closing tail of two or three
// characters gives one or two, a lone trailing character gives a single
// end-of-text marker beat, and an illegal character gives one bad_char beat
// (with end_of_text) after which characters are swallowed until the last
// flag. Results leave on o_out from a registered output, one beat per cycle
// while the sink is ready. Commands pass from the command queue into the
// output register. Throughput: one character per cycle in, one result beat
// per cycle out; the output side is the limit only while a group's three
// beats drain, and the four-entry command queue between the character front
// end and the beat sequencer absorbs that, so a stall on either side holds
// the other off only once the queue is full or empty.
module base64_unpadded_decoder_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    b64d_in_if.sink     i_in,
    b64d_out_if.source  o_out
);
    logic                 push, pop;
    b64d_pkg::t_cmd       cmd, head;
    b64d_pkg::t_q_stat    q_stat;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_char_code (i_in.char_code),
        .i_last_char (i_in.last_char),
        .i_q_full    (q_stat.full),
        .o_ready     (i_in.ready),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    b64d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (q_stat.nonempty),
        .o_pop        (pop),
        .o_out        (o_out)
    );

    // front never issues into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full) else $error("command pushed into full queue");

    // issued commands always carry one to three beats
    a_cmd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (cmd.count != 2'd0)) else $error("empty command issued");

    // an error beat closes the text and carries no byte
    a_bad_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.bad_char) |-> (o_out.end_of_text && !o_out.byte_valid))
        else $error("malformed error beat");

    // the output register is idle right after a reset edge
    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out.valid) else $error("output valid after reset");
endmodule
`default_nettype wire
